FILE: hdl/c2c_pkg.sv
`default_nettype none
package c2c_pkg;

  localparam int FracBits    = 16;
  localparam int CordicSteps = 16;
  localparam int ScFrac      = 30;
  localparam int AtanCount   = 30;

  // CORDIC datapath width: x/y stay below 2^31 in magnitude, z below 2^32
  localparam int CW = 34;

  localparam logic signed [CW-1:0] GainInv = 34'sd652032874;

  typedef logic signed [CW-1:0] cw_t;

  // Arctangent table, binary angle units (2^32 per turn)
  function automatic cw_t atan_lut(input logic [4:0] idx);
    cw_t v;
    v = '0;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933405;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335086;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41721;
      5'd15: v = 34'sd20860;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2607;
      5'd19: v = 34'sd1303;
      5'd20: v = 34'sd651;
      5'd21: v = 34'sd325;
      5'd22: v = 34'sd162;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd40;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      5'd28: v = 34'sd2;
      5'd29: v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Passthrough payload carried alongside the CORDIC
  typedef struct packed {
    logic [30:0]        radius;
    logic [31:0]        angle;
    logic signed [31:0] height;
    logic signed [31:0] rdot;
    logic signed [31:0] w;
    logic signed [31:0] zdot;
    logic               sat;
  } side_t;

endpackage
`default_nettype wire

FILE: hdl/cylindrical_to_cartesian_state_core.sv
`default_nettype none
// Cylindrical to Cartesian state converter.
// Input channel: in_valid/in_stall with radius_in, angle_in, height_in and
// their rates. Output channel: out_valid/out_stall with radius_out,
// angle_out, pos_x/y/z, vel_x/y/z and saturated.
// Pipeline: one fold stage, one register per CORDIC micro-rotation, then
// three product/saturate stages.
// Throughput: one transaction per cycle while out_stall does not hold the
// pipeline; the pipeline depth is set by the CORDIC step count.
// The whole pipeline advances together; while out_stall is high with a
// valid result waiting, every stage holds and in_stall is raised.
// Otherwise in_stall is low and empty slots are filled freely.
// Reset clears all valid bits; no result appears until items enter.
module cylindrical_to_cartesian_state_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] radius_in,
  input  wire logic signed [31:0] angle_in,
  input  wire logic signed [31:0] height_in,
  input  wire logic signed [31:0] radius_rate,
  input  wire logic signed [31:0] angle_rate,
  input  wire logic signed [31:0] height_rate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [30:0]             radius_out,
  output logic signed [31:0]      angle_out,
  output logic signed [31:0]      pos_x,
  output logic signed [31:0]      pos_y,
  output logic signed [31:0]      pos_z,
  output logic signed [31:0]      vel_x,
  output logic signed [31:0]      vel_y,
  output logic signed [31:0]      vel_z,
  output logic                    saturated
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Radius magnitude and half-turn shift
  logic           neg;
  logic [31:0]    mag;
  logic [31:0]    ang;
  c2c_pkg::side_t side;
  assign neg = radius_in[31];
  assign mag = neg ? 32'(-radius_in) : radius_in;
  assign ang = neg ? angle_in + 32'h8000_0000 : angle_in;

  always_comb begin
    side.radius = mag[31] ? 31'h7FFF_FFFF : mag[30:0];
    side.sat    = mag[31];
    side.angle  = ang;
    side.height = height_in;
    side.rdot   = radius_rate;
    side.w      = angle_rate;
    side.zdot   = height_rate;
  end

  logic           cv;
  c2c_pkg::cw_t   cc, cs;
  c2c_pkg::side_t cside;

  c2c_cordic u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_angle(ang), .in_side(side),
    .out_valid(cv), .out_cos(cc), .out_sin(cs), .out_side(cside)
  );

  c2c_mult u_mult (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(cv), .in_cos(cc), .in_sin(cs), .in_side(cside),
    .out_valid(out_valid),
    .radius_out(radius_out), .angle_out(angle_out),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .saturated(saturated)
  );

endmodule
`default_nettype wire

FILE: hdl/c2c_cordic.sv
`default_nettype none
// Pipelined rotation-mode CORDIC, one micro-rotation per stage, with a side payload.
module c2c_cordic (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [31:0]          in_angle,
  input  wire c2c_pkg::side_t       in_side,
  output logic                      out_valid,
  output c2c_pkg::cw_t              out_cos,
  output c2c_pkg::cw_t              out_sin,
  output c2c_pkg::side_t            out_side
);

  localparam int N = c2c_pkg::CordicSteps;

  logic                 vld  [N+1];
  c2c_pkg::cw_t         xs   [N+1];
  c2c_pkg::cw_t         ys   [N+1];
  c2c_pkg::cw_t         zs   [N+1];
  logic                 flp  [N+1];
  c2c_pkg::side_t       sd   [N+1];

  // Stage 0: quadrant fold into [-90, 90) degrees
  logic        flip0;
  logic [31:0] a0;
  logic [31:0] aq;
  assign aq    = in_angle + 32'h4000_0000;
  assign flip0 = aq[31];
  assign a0    = flip0 ? in_angle + 32'h8000_0000 : in_angle;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
    if (en) begin
      xs[0]  <= c2c_pkg::GainInv;
      ys[0]  <= '0;
      zs[0]  <= c2c_pkg::cw_t'($signed(a0));
      flp[0] <= flip0;
      sd[0]  <= in_side;
    end
  end

  // Micro-rotation stages
  for (genvar i = 0; i < N; i++) begin : g_stage
    c2c_pkg::cw_t dx, dy, at;
    assign dx = xs[i] >>> i;
    assign dy = ys[i] >>> i;
    assign at = c2c_pkg::atan_lut(5'(i));
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
      if (en) begin
        if (!zs[i][c2c_pkg::CW-1]) begin
          xs[i+1] <= xs[i] - dy;
          ys[i+1] <= ys[i] + dx;
          zs[i+1] <= zs[i] - at;
        end else begin
          xs[i+1] <= xs[i] + dy;
          ys[i+1] <= ys[i] - dx;
          zs[i+1] <= zs[i] + at;
        end
        flp[i+1] <= flp[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_cos   = flp[N] ? -xs[N] : xs[N];
  assign out_sin   = flp[N] ? -ys[N] : ys[N];
  assign out_side  = sd[N];

  a_flip_fold: assert property (@(posedge clk) disable iff (rst)
    en && in_valid |=> (zs[0] >= -34'sd1073741824) && (zs[0] < 34'sd1073741824))
    else $error("quadrant fold out of range");
  a_gain: assert property (@(posedge clk) disable iff (rst)
    en |=> xs[0] == c2c_pkg::GainInv && ys[0] == '0)
    else $error("cordic seed wrong");
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(out_valid))
    else $error("valid moved while stalled");

endmodule
`default_nettype wire

FILE: hdl/c2c_mult.sv
`default_nettype none
// Product stages: trig products, rate-angle product, radius scaling, final sums with saturation.
module c2c_mult (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire c2c_pkg::cw_t      in_cos,
  input  wire c2c_pkg::cw_t      in_sin,
  input  wire c2c_pkg::side_t    in_side,
  output logic                   out_valid,
  output logic [30:0]            radius_out,
  output logic signed [31:0]     angle_out,
  output logic signed [31:0]     pos_x,
  output logic signed [31:0]     pos_y,
  output logic signed [31:0]     pos_z,
  output logic signed [31:0]     vel_x,
  output logic signed [31:0]     vel_y,
  output logic signed [31:0]     vel_z,
  output logic                   saturated
);

  localparam int SF = c2c_pkg::ScFrac;
  localparam int FB = c2c_pkg::FracBits;
  localparam logic signed [63:0] HalfS = 64'sd1 <<< (SF - 1);
  localparam logic signed [63:0] HalfF = 64'sd1 <<< (FB - 1);
  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  // Stage A: R*c, R*s, rdot*c, rdot*s, w*s, w*c
  logic                 va;
  logic signed [63:0]   rc, rs, dc, ds, ws, wc;
  c2c_pkg::side_t       sa;
  logic signed [32:0]   rr;
  logic signed [31:0]   c32, s32;
  assign rr  = {2'b00, in_side.radius};
  assign c32 = in_cos[31:0];
  assign s32 = in_sin[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      rc <= 64'(rr * c32);
      rs <= 64'(rr * s32);
      dc <= 64'(in_side.rdot * c32);
      ds <= 64'(in_side.rdot * s32);
      ws <= 64'(in_side.w * s32);
      wc <= 64'(in_side.w * c32);
      sa <= in_side;
    end
  end

  // Stage B: rounding, then R * rnd(w*trig)
  logic                 vb;
  logic signed [63:0]   px_b, py_b, dc_b, ds_b, mx, my;
  c2c_pkg::side_t       sb;
  logic signed [63:0]   wsr, wcr;
  assign wsr = (ws + HalfS) >>> SF;
  assign wcr = (wc + HalfS) >>> SF;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      px_b <= (rc + HalfS) >>> SF;
      py_b <= (rs + HalfS) >>> SF;
      dc_b <= (dc + HalfS) >>> SF;
      ds_b <= (ds + HalfS) >>> SF;
      mx   <= 64'($signed({1'b0, sa.radius}) * $signed(wsr[33:0]));
      my   <= 64'($signed({1'b0, sa.radius}) * $signed(wcr[33:0]));
      sb   <= sa;
    end
  end

  // Stage C: combine and saturate
  logic signed [63:0] vxs, vys;
  assign vxs = dc_b - ((mx + HalfF) >>> FB);
  assign vys = ds_b + ((my + HalfF) >>> FB);

  function automatic logic [32:0] sat(input logic signed [63:0] v);
    if (v > Max32) return {1'b1, 32'h7FFF_FFFF};
    if (v < Min32) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  logic [32:0] spx, spy, svx, svy;
  assign spx = sat(px_b);
  assign spy = sat(py_b);
  assign svx = sat(vxs);
  assign svy = sat(vys);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
    if (en) begin
      radius_out <= sb.radius;
      angle_out  <= sb.angle;
      pos_x      <= spx[31:0];
      pos_y      <= spy[31:0];
      pos_z      <= sb.height;
      vel_x      <= svx[31:0];
      vel_y      <= svy[31:0];
      vel_z      <= sb.zdot;
      saturated  <= sb.sat | spx[32] | spy[32] | svx[32] | svy[32];
    end
  end

  a_flag: assert property (@(posedge clk) disable iff (rst)
    en && vb && (spx[32] || svy[32]) |=> saturated)
    else $error("saturation flag lost");
  a_pass: assert property (@(posedge clk) disable iff (rst)
    en && vb |=> radius_out == $past(sb.radius))
    else $error("radius not carried");
  a_val: assert property (@(posedge clk) disable iff (rst)
    en |=> out_valid == $past(vb))
    else $error("valid not carried");

endmodule
`default_nettype wire
